// ===== rtl/core/kkmf_pkg.sv =====
// shared types and constants for the k-way k-mer merge filter
package kkmf_pkg;

    localparam int KMER_W  = 62;
    localparam int SMP_W   = 4;
    localparam int CNT_W   = 32;
    localparam int OCNT_W  = 16;
    localparam int MASK_W  = 16;
    localparam int MINS_W  = 5;
    localparam int MULT_W  = 16;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MULT    = 1'd1;

    typedef struct packed {
        logic [SMP_W-1:0]  sample;
        logic [KMER_W-1:0] kmer;
        logic [CNT_W-1:0]  count;
        logic              stream_end;
    } t_in_item;

    typedef struct packed {
        logic              emit;
        logic [KMER_W-1:0] kmer_out;
        logic [SMP_W-1:0]  sample_out;
        logic [OCNT_W-1:0] count_out;
        logic [MASK_W-1:0] refill_mask;
        logic              last;
        logic              done_res;
    } t_out_item;

    // token passed along the cell chain during a min search
    typedef struct packed {
        logic              found;
        logic [KMER_W-1:0] minv;
    } t_min_tok;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_SCAN,
        ST_SUM,
        ST_DECIDE,
        ST_EMIT,
        ST_DROP,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/core/kkmf_cell.sv =====
// one head cell: holds a sample's head record, compares against the passing min token
module kkmf_cell
    import kkmf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_wr,
    input  logic [KMER_W-1:0] i_kmer,
    input  logic [CNT_W-1:0]  i_count,
    input  logic              i_live,
    input  t_min_tok          i_tok,
    output t_min_tok          o_tok,
    input  logic [KMER_W-1:0] i_final_min,
    output logic              o_match,
    output logic [CNT_W-1:0]  o_count
);

    logic [KMER_W-1:0] r_kmer;
    logic [CNT_W-1:0]  r_count;

    // head record storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_kmer  <= i_kmer;
            r_count <= i_count;
        end
    end

    // pass the running minimum to the neighbor
    always_comb begin
        o_tok = i_tok;
        if (i_live && (!i_tok.found || r_kmer < i_tok.minv)) begin
            o_tok.found = 1'b1;
            o_tok.minv  = r_kmer;
        end
    end

    assign o_match = i_live && (r_kmer == i_final_min);
    assign o_count = r_count;

endmodule

// ===== rtl/core/kway_kmer_merge_filter.sv =====
// top level of the k-way k-mer merge filter
// Keeps one head record per sample in a row of cells. A record refills a pending head.
// Once every head is filled, a token walks the cell row one cell a cycle through a
// registered chain to find the smallest live k-mer. The matching counts are then summed
// one sample a cycle, followed by a decide state. A kept k-mer is sent as SAMPLES
// results, one per cycle while the result sink does not stall; a dropped one is sent as
// a single result. When every stream has ended, one done result is sent. A new record
// is taken only after the last result has been transferred.
module kway_kmer_merge_filter
    import kkmf_pkg::*;
#(
    parameter int SAMPLES  = 16,
    parameter int KMER_LEN = 31
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in_item             i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out_item            o_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int CTR_W = $clog2(SAMPLES + 1);
    localparam int SUM_W = CNT_W + CTR_W;
    localparam logic [KMER_W-1:0] KMASK =
        (KMER_LEN >= 31) ? {KMER_W{1'b1}} : KMER_W'((64'd1 << (2 * KMER_LEN)) - 64'd1);

    t_state r_state, n_state;
    logic [SAMPLES-1:0] r_live, r_pend, r_match;
    logic [MINS_W-1:0]  r_min_samples;
    logic [MULT_W-1:0]  r_min_mult;
    logic [CTR_W-1:0]   r_ctr;
    logic [CTR_W-1:0]   r_nmatch;
    logic [SUM_W-1:0]   r_sum;
    t_min_tok           r_tok;
    logic [KMER_W-1:0]  r_minv;
    logic               r_ovalid, n_ovalid;
    t_out_item          r_out;

    t_min_tok          tok_out [SAMPLES];
    logic [SAMPLES-1:0] cell_match;
    logic [CNT_W-1:0]  cell_cnt [SAMPLES];
    logic [SAMPLES-1:0] wr_sel;
    logic [IDX_W-1:0]  ctr_idx;
    logic              in_ok, acc, out_free, keep;
    logic [MASK_W-1:0] mask16;
    logic [CNT_W-1:0]  cur_cnt;

    assign ctr_idx  = r_ctr[IDX_W-1:0];
    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == ST_FILL) && !r_ovalid;
    assign acc      = i_valid && o_ready;
    assign in_ok    = ({1'b0, i_data.sample} < (SMP_W+1)'(SAMPLES))
                      && r_pend[IDX_W'(i_data.sample)];
    assign o_cfg_ready = 1'b1;
    assign mask16   = MASK_W'(r_match);
    assign cur_cnt  = cell_cnt[ctr_idx];
    assign keep = ({{(8-CTR_W){1'b0}}, r_nmatch} >= {3'b0, r_min_samples})
                  && (r_nmatch > CTR_W'(1) || r_sum > SUM_W'(r_min_mult));

    // cell row; the token enters the cell selected by the scan counter from the register
    for (genvar g = 0; g < SAMPLES; g++) begin : g_cell
        assign wr_sel[g] = acc && in_ok && !i_data.stream_end && (i_data.sample == SMP_W'(g));
        kkmf_cell u_cell (
            .i_clk       (i_clk),
            .i_wr        (wr_sel[g]),
            .i_kmer      (i_data.kmer & KMASK),
            .i_count     (i_data.count),
            .i_live      (r_live[g]),
            .i_tok       (r_tok),
            .o_tok       (tok_out[g]),
            .i_final_min (r_minv),
            .o_match     (cell_match[g]),
            .o_count     (cell_cnt[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_FILL: begin
                if (acc && in_ok && (r_pend & ~(SAMPLES'(1) << i_data.sample)) == '0) begin
                    if ((r_live & ~({SAMPLES{i_data.stream_end}}
                         & (SAMPLES'(1) << i_data.sample))) == '0)
                        n_state = ST_DONE;
                    else
                        n_state = ST_SCAN;
                end
            end
            ST_SCAN:   if (r_ctr == CTR_W'(SAMPLES - 1)) n_state = ST_SUM;
            ST_SUM:    if (r_ctr == CTR_W'(SAMPLES - 1)) n_state = ST_DECIDE;
            ST_DECIDE: n_state = keep ? ST_EMIT : ST_DROP;
            ST_EMIT:   if (out_free && r_ctr == CTR_W'(SAMPLES - 1)) n_state = ST_FILL;
            ST_DROP:   if (out_free) n_state = ST_FILL;
            ST_DONE:   n_state = ST_DONE;
            default:   n_state = ST_FILL;
        endcase
    end

    // result valid: cleared by a transfer, set when a new result is loaded
    always_comb begin
        n_ovalid = r_ovalid && !i_ready;
        case (r_state)
            ST_FILL:          if (n_state == ST_DONE) n_ovalid = 1'b1;
            ST_EMIT, ST_DROP: if (out_free) n_ovalid = 1'b1;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_FILL;
            r_live        <= '1;
            r_pend        <= '1;
            r_min_samples <= MINS_W'(1);
            r_min_mult    <= MULT_W'(5);
            r_ovalid      <= 1'b0;
            r_ctr         <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MIN_SAMPLES: r_min_samples <= i_cfg_data[MINS_W-1:0];
                    CFG_MIN_MULT:    r_min_mult    <= i_cfg_data[MULT_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_FILL: begin
                    r_ctr <= '0;
                    if (acc && in_ok) begin
                        r_pend[IDX_W'(i_data.sample)] <= 1'b0;
                        if (i_data.stream_end) r_live[IDX_W'(i_data.sample)] <= 1'b0;
                    end
                end
                ST_SCAN, ST_SUM: begin
                    r_ctr <= (r_ctr == CTR_W'(SAMPLES - 1)) ? '0 : r_ctr + CTR_W'(1);
                end
                ST_DECIDE: begin
                    r_ctr  <= '0;
                    r_pend <= r_match;
                end
                ST_EMIT: begin
                    if (out_free) r_ctr <= r_ctr + CTR_W'(1);
                end
                default: ;
            endcase
        end
    end

    // datapath registers: min token walk, match sum, result staging
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_FILL: begin
                r_tok    <= '0;
                r_nmatch <= '0;
                r_sum    <= '0;
                // all streams ended
                if (n_state == ST_DONE) begin
                    r_out.emit        <= 1'b0;
                    r_out.kmer_out    <= '0;
                    r_out.sample_out  <= '0;
                    r_out.count_out   <= '0;
                    r_out.refill_mask <= '0;
                    r_out.last        <= 1'b1;
                    r_out.done_res    <= 1'b1;
                end
            end
            ST_SCAN: begin
                r_tok <= tok_out[ctr_idx];
                if (r_ctr == CTR_W'(SAMPLES - 1)) r_minv <= tok_out[ctr_idx].minv;
            end
            ST_SUM: begin
                r_match[ctr_idx] <= cell_match[ctr_idx];
                if (cell_match[ctr_idx]) begin
                    r_nmatch <= r_nmatch + CTR_W'(1);
                    r_sum    <= r_sum + SUM_W'(cur_cnt);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    r_out.emit        <= 1'b1;
                    r_out.kmer_out    <= r_minv;
                    r_out.sample_out  <= SMP_W'(ctr_idx);
                    r_out.count_out   <= !r_match[ctr_idx] ? '0 :
                                         (cur_cnt > CNT_W'(16'hFFFF)) ? 16'hFFFF
                                         : cur_cnt[OCNT_W-1:0];
                    r_out.refill_mask <= mask16;
                    r_out.last        <= (r_ctr == CTR_W'(SAMPLES - 1));
                    r_out.done_res    <= 1'b0;
                end
            end
            ST_DROP: begin
                if (out_free) begin
                    r_out.emit        <= 1'b0;
                    r_out.kmer_out    <= r_minv;
                    r_out.sample_out  <= '0;
                    r_out.count_out   <= '0;
                    r_out.refill_mask <= mask16;
                    r_out.last        <= 1'b1;
                    r_out.done_res    <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule

// ===== sim/kway_kmer_merge_filter_tb.sv =====
// testbench for the k-way k-mer merge filter: random streams checked against a built-in predictor
module kway_kmer_merge_filter_tb;
    import kkmf_pkg::*;

    localparam int NSMP = 16;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    t_in_item             i_data;
    logic                 o_valid;
    logic                 i_ready;
    t_out_item            o_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    kway_kmer_merge_filter #(.SAMPLES(NSMP), .KMER_LEN(31)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [KMER_W-1:0] head_k [NSMP];
    logic [CNT_W-1:0]  head_c [NSMP];
    logic [NSMP-1:0]   live_m;
    logic [NSMP-1:0]   pend_m;
    logic [MINS_W-1:0] min_smp_r;
    logic [MULT_W-1:0] min_mult_r;
    bit                all_dead;

    t_out_item         merged_q[$];
    t_out_item         want;
    int                n_fail;
    bit                fast_src;
    bit                fast_sink;
    logic [KMER_W-1:0] phase_base;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #40000000;
        $display("Verification failed");
        $finish;
    end

    // merge one record into the heads and queue the results it causes
    task automatic merge_predict(input t_in_item it);
        logic [KMER_W-1:0] minv;
        logic [NSMP-1:0]   match;
        logic [35:0]       sum;
        logic [CNT_W-1:0]  c;
        int                cnt;
        bit                found;
        t_out_item         r;
        begin
            if (!pend_m[it.sample]) return;
            if (it.stream_end) live_m[it.sample] = 1'b0;
            else begin
                head_k[it.sample] = it.kmer;
                head_c[it.sample] = it.count;
            end
            pend_m[it.sample] = 1'b0;
            if (pend_m != '0) return;
            r = '0;
            r.last = 1'b1;
            if (live_m == '0) begin
                r.done_res = 1'b1;
                merged_q = {merged_q, r};
                all_dead = 1'b1;
                return;
            end
            found = 0; match = '0; cnt = 0; sum = '0; minv = '0;
            for (int i = 0; i < NSMP; i++) begin
                if (!live_m[i]) continue;
                if (!found || head_k[i] < minv) begin
                    minv = head_k[i]; found = 1; match = '0; cnt = 0; sum = '0;
                end
                if (head_k[i] == minv) begin
                    match[i] = 1'b1; cnt++; sum += head_c[i];
                end
            end
            pend_m = match;
            r.kmer_out = minv;
            r.refill_mask = match;
            if (cnt >= min_smp_r && (cnt > 1 || sum > min_mult_r)) begin
                for (int i = 0; i < NSMP; i++) begin
                    c = match[i] ? head_c[i] : '0;
                    r.emit = 1'b1;
                    r.sample_out = i[SMP_W-1:0];
                    r.count_out = (c > 32'hFFFF) ? 16'hFFFF : c[OCNT_W-1:0];
                    r.last = (i == NSMP - 1);
                    merged_q = {merged_q, r};
                end
            end else
                merged_q = {merged_q, r};
        end
    endtask

    // one record transfer
    task automatic send_rec(input t_in_item it);
        int gap;
        begin
            gap = fast_src ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_data  <= it;
            i_valid <= 1'b1;
            do @(posedge i_clk); while (!o_ready);
            merge_predict(it);
        end
    endtask

    // wait until the block has delivered everything and gone quiet
    task automatic settle();
        begin
            i_valid <= 1'b0;
            while (merged_q.size() > 0) @(posedge i_clk);
            repeat (80) @(posedge i_clk);
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            do @(posedge i_clk); while (!o_cfg_ready);
            i_cfg_valid <= 1'b0;
            if (idx == CFG_MIN_SAMPLES) min_smp_r = val[MINS_W-1:0];
            else min_mult_r = val[MULT_W-1:0];
            @(posedge i_clk);
        end
    endtask

    function automatic t_in_item mk_rec(input int s, input logic [KMER_W-1:0] k,
                                        input logic [CNT_W-1:0] c, input bit e);
        t_in_item it;
        it.sample = s[SMP_W-1:0];
        it.kmer = k;
        it.count = c;
        it.stream_end = e;
        return it;
    endfunction

    function automatic int pick_sample(input bit want_pending);
        int list[$];
        for (int i = 0; i < NSMP; i++)
            if (pend_m[i] == want_pending) list = {list, i};
        if (list.size() == 0) return -1;
        return list[$urandom_range(0, list.size() - 1)];
    endfunction

    function automatic logic [CNT_W-1:0] rand_count();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 10);
            2:       return 32'hFFFF;
            3:       return 32'h10000;
            default: return $urandom_range(0, 100000);
        endcase
    endfunction

    function automatic t_in_item rand_rec();
        logic [63:0] wide;
        int          s;
        wide = {$urandom, $urandom};
        s = pick_sample(1'b0);
        // stray record for a sample that is not waiting
        if (s >= 0 && $urandom_range(0, 9) == 0)
            return mk_rec(s, wide[KMER_W-1:0], rand_count(), $urandom_range(0, 1));
        s = pick_sample(1'b1);
        if ($countones(live_m) > 2 && $urandom_range(0, 33) == 0)
            return mk_rec(s, wide[KMER_W-1:0], $urandom, 1'b1);
        if ($urandom_range(0, 9) < 7)
            return mk_rec(s, phase_base + $urandom_range(0, 3), rand_count(), 1'b0);
        return mk_rec(s, wide[KMER_W-1:0], rand_count(), 1'b0);
    endfunction

    // result sink with random stalls
    initial begin
        int n;
        i_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = fast_sink ? 0 : $urandom_range(0, 19);
            if (n > 0) begin
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (merged_q.size() == 0) begin
                $error("unexpected result: kmer_out %h", o_data.kmer_out);
                n_fail++;
            end else begin
                want = merged_q.pop_front();
                if (o_data.emit !== want.emit) begin
                    $error("emit exp %0d got %0d", want.emit, o_data.emit); n_fail++;
                end
                if (o_data.kmer_out !== want.kmer_out) begin
                    $error("kmer_out exp %h got %h", want.kmer_out, o_data.kmer_out); n_fail++;
                end
                if (o_data.sample_out !== want.sample_out) begin
                    $error("sample_out exp %0d got %0d", want.sample_out, o_data.sample_out);
                    n_fail++;
                end
                if (o_data.count_out !== want.count_out) begin
                    $error("count_out exp %0d got %0d", want.count_out, o_data.count_out);
                    n_fail++;
                end
                if (o_data.refill_mask !== want.refill_mask) begin
                    $error("refill_mask exp %h got %h", want.refill_mask, o_data.refill_mask);
                    n_fail++;
                end
                if (o_data.last !== want.last) begin
                    $error("last exp %0d got %0d", want.last, o_data.last); n_fail++;
                end
                if (o_data.done_res !== want.done_res) begin
                    $error("done_res exp %0d got %0d", want.done_res, o_data.done_res); n_fail++;
                end
            end
        end
    end

    // edge values: lone small k-mer dropped then kept, all-ones k-mer shared by every sample
    task automatic test_directed();
        begin
            fast_src = 1; fast_sink = 1;
            send_rec(mk_rec(0, '0, 32'd3, 1'b0));
            send_rec(mk_rec(0, '1, 32'd9, 1'b0));   // not pending, ignored
            for (int i = 1; i < NSMP; i++)
                send_rec(mk_rec(i, '1, (i % 3 == 0) ? 32'hFFFF_FFFF :
                                       (i % 3 == 1) ? 32'h10000 : 32'hFFFF, 1'b0));
            send_rec(mk_rec(0, 62'd1, 32'd6, 1'b0));
            send_rec(mk_rec(0, '1, 32'd0, 1'b0));
            settle();
        end
    endtask

    task automatic test_random_phase(input logic [31:0] mins, input logic [31:0] mult,
                                     input int n_items);
        begin
            logic [63:0] wide;
            cfg_write(CFG_MIN_SAMPLES, mins);
            cfg_write(CFG_MIN_MULT, mult);
            wide = {$urandom, $urandom};
            phase_base = wide[KMER_W-1:0];
            fast_src = ($urandom_range(0, 3) == 0);
            fast_sink = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < n_items; i++) send_rec(rand_rec());
            settle();
        end
    endtask

    // close every stream until the block reports done
    task automatic test_all_streams_end();
        begin
            fast_src = 0; fast_sink = 0;
            while (!all_dead) send_rec(mk_rec(pick_sample(1'b1), '0, '0, 1'b1));
            settle();
        end
    endtask

    initial begin
        n_fail = 0;
        all_dead = 0;
        live_m = '1;
        pend_m = '1;
        min_smp_r = 5'd1;
        min_mult_r = 16'd5;
        phase_base = '0;
        fast_src = 0;
        fast_sink = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_MIN_SAMPLES;
        i_cfg_data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(32'd0, 32'd0, 50);
        test_random_phase(32'd16, 32'd65535, 40);
        test_random_phase(32'd1, 32'd5, 50);
        test_random_phase(32'd2, 32'd100, 40);
        test_random_phase($urandom_range(0, 3), $urandom_range(0, 65535), 50);
        test_all_streams_end();

        if (n_fail == 0 && merged_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
